// ----- rtl/core/npd_pkg.sv -----
// ----------------------------------------------------------------------------
// npd_pkg: shared types and constants for the nav packet deframer
// Queue item layout, item kinds and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package npd_pkg;

	localparam int HDR_BYTES = 5;   // LRC, ID, length, CRC low, CRC high
	localparam int LRC_SPAN  = 4;   // bytes held in the header window

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Item kinds as classified by the front end
	localparam logic [1:0] KIND_HUNT = 2'd0;  // byte seen while hunting, no header
	localparam logic [1:0] KIND_HDR  = 2'd1;  // byte completed a header
	localparam logic [1:0] KIND_DATA = 2'd2;  // payload byte

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [7:0]  index;
		logic        last;
		logic [7:0]  id;
		logic [7:0]  len;
		logic [15:0] exp_crc;
	} npd_item_t;

	// One byte through CRC-16/CCITT-FALSE, MSB first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/nav_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// nav_packet_deframer: byte-serial deframer for LRC/CRC-16 headed packets
// Hunts for a 5-byte header, streams payload bytes, checks payload CRC.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: one received byte per beat on rx_byte, in_valid/in_stall.
//  - Output channel: exactly one result beat per input beat, same order,
//    on out_valid/out_stall. Hunting bytes give an all-zero result.
//  - Header = LRC, ID, length, CRC low, CRC high. A header beat raises
//    header_found with packet_id/packet_len; the next length beats carry
//    payload_valid and a running payload_index. The last one raises
//    frame_end, and crc_good if the payload CRC-16/CCITT-FALSE matches.
//    A zero-length header ends the frame on the header beat itself.
//  - Throughput: one beat per cycle sustained while out_stall is low. The
//    CRC step is one 8-bit unrolled update in the back end; header LRC is
//    a 5-byte add in front.
//  - Path: an accepted beat is written into the queue, then loaded into the
//    result register on pop; its result is offered from that register.
//  - Receiver stall: the result register holds, the queue takes up to
//    QUEUE_DEPTH more beats, then in_stall rises until space frees.
//  - Reset (arst_n low): queue empty, hunting, empty window, CRC at 0xFFFF.
// ----------------------------------------------------------------------------
module nav_packet_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       header_found,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic       frame_end,
	output logic       crc_good,
	output logic [7:0] packet_id,
	output logic [7:0] packet_len
);
	import npd_pkg::*;

	npd_item_t front_item;
	npd_item_t queue_item;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;
	logic      take;

	// front side takes a beat whenever the queue has room
	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	npd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.item    (front_item)
	);

	npd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.wr_item (front_item),
		.full    (q_full),
		.pop     (q_pop),
		.rd_item (queue_item),
		.empty   (q_empty)
	);

	npd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (queue_item),
		.item_avail    (!q_empty),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.header_found  (header_found),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_end     (frame_end),
		.crc_good      (crc_good),
		.packet_id     (packet_id),
		.packet_len    (packet_len)
	);

	// a CRC verdict only ever comes with a frame end
	a_crc_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crc_good |-> frame_end)
		else $error("crc_good without frame_end");

	// a beat is never both header and payload
	a_hdr_not_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_found |-> !payload_valid)
		else $error("header and payload flagged together");

	// hunting beats carry no packet context
	a_hunt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !header_found && !payload_valid |->
			!frame_end && packet_id == 8'd0 && packet_len == 8'd0)
		else $error("hunting beat carries packet fields");

	// nothing leaves the back end unless the queue had an entry
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

endmodule

// ----- rtl/core/npd_front.sv -----
// ----------------------------------------------------------------------------
// npd_front: header hunt and byte classification
// Keeps the sliding header window and packet counters, tags each beat.
// ----------------------------------------------------------------------------
module npd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output npd_pkg::npd_item_t item
);
	import npd_pkg::*;

	// last four bytes seen; win_q[0] is the oldest (candidate LRC byte)
	logic [7:0]  win_q [LRC_SPAN];
	logic [2:0]  fill_q;
	logic        in_pkt_q;
	logic [7:0]  taken_q;
	logic [7:0]  len_q;
	logic [7:0]  id_q;
	logic [15:0] exp_crc_q;

	logic [7:0] lrc_sum;
	logic       hdr_hit;
	logic [7:0] taken_nxt;
	logic       data_last;

	assign lrc_sum   = win_q[0] + win_q[1] + win_q[2] + win_q[3] + rx_byte;
	// window full once this byte enters: four already held
	assign hdr_hit   = (fill_q >= 3'(LRC_SPAN)) && (lrc_sum == 8'h00);
	assign taken_nxt = taken_q + 8'd1;
	assign data_last = (taken_nxt >= len_q);

	always_comb begin
		item = '0;
		if (in_pkt_q) begin
			item.kind    = KIND_DATA;
			item.data    = rx_byte;
			item.index   = taken_q;
			item.last    = data_last;
			item.id      = id_q;
			item.len     = len_q;
			item.exp_crc = exp_crc_q;
		end else if (hdr_hit) begin
			item.kind    = KIND_HDR;
			item.id      = win_q[1];
			item.len     = win_q[2];
			item.exp_crc = {rx_byte, win_q[3]};
			item.last    = (win_q[2] == 8'd0);
		end else begin
			item.kind    = KIND_HUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LRC_SPAN; i++) win_q[i] <= '0;
			fill_q    <= '0;
			in_pkt_q  <= 1'b0;
			taken_q   <= '0;
			len_q     <= '0;
			id_q      <= '0;
			exp_crc_q <= '0;
		end else if (take) begin
			if (in_pkt_q) begin
				taken_q <= taken_nxt;
				if (data_last) begin
					in_pkt_q <= 1'b0;
					fill_q   <= '0;
					for (int i = 0; i < LRC_SPAN; i++) win_q[i] <= '0;
				end
			end else if (hdr_hit) begin
				id_q      <= win_q[1];
				len_q     <= win_q[2];
				exp_crc_q <= {rx_byte, win_q[3]};
				taken_q   <= '0;
				in_pkt_q  <= (win_q[2] != 8'd0);
				fill_q    <= '0;
				for (int i = 0; i < LRC_SPAN; i++) win_q[i] <= '0;
			end else begin
				for (int i = 0; i < LRC_SPAN - 1; i++) win_q[i] <= win_q[i+1];
				win_q[LRC_SPAN-1] <= rx_byte;
				if (fill_q < 3'(HDR_BYTES)) fill_q <= fill_q + 3'd1;
			end
		end
	end

endmodule

// ----- rtl/core/npd_queue.sv -----
// ----------------------------------------------------------------------------
// npd_queue: short FIFO between classifier and CRC back end
// Register-based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module npd_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  npd_pkg::npd_item_t wr_item,
	output logic               full,
	input  logic               pop,
	output npd_pkg::npd_item_t rd_item,
	output logic               empty
);
	import npd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	npd_item_t        mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ----- rtl/core/npd_back.sv -----
// ----------------------------------------------------------------------------
// npd_back: running CRC and result register
// Pops classified beats, updates the payload CRC, holds one result.
// ----------------------------------------------------------------------------
module npd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  npd_pkg::npd_item_t item,
	input  logic               item_avail,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               header_found,
	output logic               payload_valid,
	output logic [7:0]         payload_byte,
	output logic [7:0]         payload_index,
	output logic               frame_end,
	output logic               crc_good,
	output logic [7:0]         packet_id,
	output logic [7:0]         packet_len
);
	import npd_pkg::*;

	logic        vld_q;
	logic [15:0] crc_q;
	logic [15:0] crc_nxt;

	assign pop       = item_avail && (!vld_q || !out_stall);
	assign out_valid = vld_q;
	assign crc_nxt   = crc_update(crc_q, item.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			crc_q <= CRC_INIT;
		end else begin
			if (pop) vld_q <= 1'b1;
			else if (!out_stall) vld_q <= 1'b0;
			if (pop) begin
				if (item.kind == KIND_HDR) crc_q <= CRC_INIT;
				else if (item.kind == KIND_DATA) crc_q <= crc_nxt;
			end
		end
	end

	// result payload, loaded only on pop
	always_ff @(posedge clk) begin
		if (pop) begin
			header_found  <= 1'b0;
			payload_valid <= 1'b0;
			payload_byte  <= '0;
			payload_index <= '0;
			frame_end     <= 1'b0;
			crc_good      <= 1'b0;
			packet_id     <= '0;
			packet_len    <= '0;
			unique case (item.kind)
				KIND_HDR: begin
					header_found <= 1'b1;
					packet_id    <= item.id;
					packet_len   <= item.len;
					frame_end    <= item.last;
					crc_good     <= item.last && (item.exp_crc == CRC_INIT);
				end
				KIND_DATA: begin
					payload_valid <= 1'b1;
					payload_byte  <= item.data;
					payload_index <= item.index;
					packet_id     <= item.id;
					packet_len    <= item.len;
					frame_end     <= item.last;
					crc_good      <= item.last && (crc_nxt == item.exp_crc);
				end
				default: begin
					header_found <= 1'b0;
				end
			endcase
		end
	end

endmodule
